// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// File: design/psf1d_pkg.sv
// ----------------------------------------------------------------------------
// psf1d_pkg
// word types and constants of the psf1 font stream decoder
// ----------------------------------------------------------------------------
package psf1d_pkg;

   localparam logic [7:0] MAGIC0_BYTE = 8'h36;
   localparam logic [7:0] MAGIC1_BYTE = 8'h04;

   // glyph count of a narrow font, doubled by the mode bit
   localparam int unsigned GLYPHS_PER_MODE_STEP = 256;

   localparam logic [1:0] STATUS_ROW        = 2'd0;
   localparam logic [1:0] STATUS_BAD_MAGIC  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_HEIGHT = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_font;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [8:0]  glyph_index;
      logic [7:0]  row_index;
      logic [7:0]  glyph_height;
      logic [63:0] pixels;
      logic        last;
   } rsp_word_type;

endpackage

// File: design/psf1d_parse.sv
// ----------------------------------------------------------------------------
// psf1d_parse
// input register, header parser and glyph row expansion
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psf1d_parse
   import psf1d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   input  logic         res_ready,
   output logic         res_valid,
   output rsp_word_type res_word
);

   localparam logic [2:0] PH_MAGIC0 = 3'd0;
   localparam logic [2:0] PH_MAGIC1 = 3'd1;
   localparam logic [2:0] PH_MODE   = 3'd2;
   localparam logic [2:0] PH_HEIGHT = 3'd3;
   localparam logic [2:0] PH_ROWS   = 3'd4;
   localparam logic [2:0] PH_IDLE   = 3'd5;

   localparam logic [9:0] NARROW_COUNT = 10'(GLYPHS_PER_MODE_STEP);
   localparam logic [9:0] WIDE_COUNT   = 10'(2 * GLYPHS_PER_MODE_STEP);

   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic [2:0]   phase_ff, phase_in;
   logic         magic_ok_ff, magic_ok_in;
   logic         wide_ff, wide_in;
   logic [7:0]   height_ff, height_in;
   logic [8:0]   glyph_ff, glyph_in;
   logic [7:0]   row_ff, row_in;

   logic         go;
   logic [2:0]   cur_phase;
   logic         last_row, last_glyph;
   logic [63:0]  expanded;

   assign go          = s1_valid_ff && res_ready;
   assign req_ready   = !s1_valid_ff || res_ready;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_word_ff <= req_word;
      end
   end

   assign cur_phase  = s1_word_ff.start_of_font ? PH_MAGIC0 : phase_ff;
   assign last_row   = ({1'b0, row_ff} + 9'd1) == {1'b0, height_ff};
   assign last_glyph = ({1'b0, glyph_ff} + 10'd1) == (wide_ff ? WIDE_COUNT : NARROW_COUNT);

   // msb of the row byte lands in the top pixel
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         expanded[k*8 +: 8] = {8{s1_word_ff.data_byte[k]}};
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      magic_ok_in = magic_ok_ff;
      wide_in     = wide_ff;
      height_in   = height_ff;
      glyph_in    = glyph_ff;
      row_in      = row_ff;
      res_valid   = 1'b0;
      res_word    = '0;
      unique case (cur_phase)
         PH_MAGIC0: begin
            magic_ok_in = (s1_word_ff.data_byte == MAGIC0_BYTE);
            phase_in    = PH_MAGIC1;
         end
         PH_MAGIC1: begin
            if (!(magic_ok_ff && s1_word_ff.data_byte == MAGIC1_BYTE)) begin
               phase_in        = PH_IDLE;
               res_valid       = go;
               res_word.status = STATUS_BAD_MAGIC;
            end else begin
               phase_in = PH_MODE;
            end
         end
         PH_MODE: begin
            wide_in  = s1_word_ff.data_byte[0];
            phase_in = PH_HEIGHT;
         end
         PH_HEIGHT: begin
            height_in = s1_word_ff.data_byte;
            glyph_in  = '0;
            row_in    = '0;
            if (s1_word_ff.data_byte == 8'd0) begin
               phase_in        = PH_IDLE;
               res_valid       = go;
               res_word.status = STATUS_ZERO_HEIGHT;
            end else begin
               phase_in = PH_ROWS;
            end
         end
         PH_ROWS: begin
            res_valid             = go;
            res_word.status       = STATUS_ROW;
            res_word.glyph_index  = glyph_ff;
            res_word.row_index    = row_ff;
            res_word.glyph_height = height_ff;
            res_word.pixels       = expanded;
            res_word.last         = last_row && last_glyph;
            if (last_row) begin
               row_in   = '0;
               glyph_in = glyph_ff + 9'd1;
               if (last_glyph) begin
                  phase_in = PH_IDLE;
               end
            end else begin
               row_in = row_ff + 8'd1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         phase_ff    <= PH_MAGIC0;
         magic_ok_ff <= 1'b0;
         wide_ff     <= 1'b0;
         height_ff   <= '0;
         glyph_ff    <= '0;
         row_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (go) begin
            phase_ff    <= phase_in;
            magic_ok_ff <= magic_ok_in;
            wide_ff     <= wide_in;
            height_ff   <= height_in;
            glyph_ff    <= glyph_in;
            row_ff      <= row_in;
         end
      end
   end

   // errors and the final row leave the parser idle, and a stall holds its state
   `ASSERT_PROP(a_last_goes_idle, clock, reset, (res_valid && res_word.last) |=> (phase_ff == PH_IDLE))
   `ASSERT_PROP(a_error_goes_idle, clock, reset, (res_valid && res_word.status != STATUS_ROW) |=> (phase_ff == PH_IDLE))
   `ASSERT_PROP(a_hold_when_stalled, clock, reset, !go |=> ($stable(phase_ff) && $stable(row_ff) && $stable(glyph_ff)))

endmodule

// File: design/psf1d_out_buf.sv
// ----------------------------------------------------------------------------
// psf1d_out_buf
// two-entry result buffer decoupling the parser from the result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psf1d_out_buf
   import psf1d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         push_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic [1:0]   count_ff, count_in;
   rsp_word_type head_ff, tail_ff;
   logic         pop;

   assign push_ready = (count_ff != 2'd2);
   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_word   = head_ff;
   assign pop        = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         // shift the waiting word forward, or refill from the parser
         head_ff <= (push && count_ff == 2'd1) ? push_word : tail_ff;
      end else if (push && count_ff == 2'd0) begin
         head_ff <= push_word;
      end
      if (push && ((count_ff == 2'd1 && !pop) || count_ff == 2'd2)) begin
         tail_ff <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `ASSERT_NEVER(a_push_when_full, clock, reset, push && count_ff == 2'd2)
   `ASSERT_NEVER(a_count_range, clock, reset, count_ff == 2'd3)
   `ASSERT_PROP(a_pop_drains, clock, reset, (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))

endmodule

// File: design/psf1_font_stream_decoder.sv
// path: an accepted byte is registered in the parser input stage, then its result word in the buffer head
// throughput: one byte per cycle while the result buffer has room, set by the single-pass parser register stage
// a two-entry result buffer keeps req_ready high while one result waits
// reset: synchronous, active high; parser returns to header byte zero
// and the buffer empties, so the first byte after reset is read as magic
// ----------------------------------------------------------------------------
// psf1_font_stream_decoder
// parses a psf1 font byte stream and expands each glyph row into pixels
// ----------------------------------------------------------------------------
module psf1_font_stream_decoder
   import psf1d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // font byte words
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   // pixel row and error words
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   // parser to buffer handoff
   logic         res_valid;
   logic         res_ready;
   rsp_word_type res_word;

   // header check, counters and bit fan-out, one byte per cycle unless the buffer is full
   psf1d_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .res_ready (res_ready),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // result words wait here while the consumer stalls
   psf1d_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_word  (res_word),
      .push_ready (res_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// regression for the psf1 font stream decoder: byte words are driven through
// a valid/ready channel under random idling and long stalls, every accepted
// byte runs through a behavioral parser here, and each row or error word that
// comes out is compared field by field with the oldest predicted word
// ----------------------------------------------------------------------------
module tb_top;
   import psf1d_pkg::*;

   localparam int unsigned HALF_PERIOD  = 4;
   localparam int unsigned RESET_CYCLES = 9;
   // extra wait after the last predicted word has come back
   localparam int unsigned DRAIN_PAD    = 6;
   localparam int unsigned LONG_HOLD    = 200;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned RANDOM_ITEMS = 400;
   // final stretch of the random part runs without random idling on either side
   localparam int unsigned CALM_ITEMS   = 100;

   // parser phases of the behavioral decoder
   typedef enum logic [2:0] {
      AT_MAGIC0, AT_MAGIC1, AT_MODE, AT_HEIGHT, AT_ROWS, AT_IDLE
   } parse_phase_e;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   // behavioral parser state
   parse_phase_e phase_now = AT_MAGIC0;
   logic         magic0_seen = 1'b0;
   logic         wide = 1'b0;
   logic [7:0]   rows_per_glyph = '0;
   logic [8:0]   glyph_no = '0;
   logic [7:0]   row_no = '0;

   rsp_word_type expected_rows[$];
   int unsigned  parsed_bytes = 0;
   int unsigned  error_count = 0;
   int unsigned  quiet_cycles = 0;
   bit           idle_on = 1'b1;
   bit           long_hold_req = 1'b0;

   psf1_font_stream_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // each set bit becomes a 255 pixel, msb leftmost in the top byte
   function automatic logic [63:0] fan_out_row(input logic [7:0] b);
      logic [63:0] px;
      px = '0;
      for (int k = 0; k < 8; k++) begin
         px[63 - 8 * k -: 8] = b[7 - k] ? 8'hFF : 8'h00;
      end
      return px;
   endfunction

   // advance the parser by one accepted byte and queue what it yields
   task automatic decode_byte(input req_word_type w);
      rsp_word_type row;
      logic         last_row;
      logic         last_glyph;
      int unsigned  glyph_total;
      row = '0;
      // a start flag restarts parsing from any phase
      if (w.start_of_font) phase_now = AT_MAGIC0;
      if (phase_now != AT_IDLE) parsed_bytes++;
      case (phase_now)
         AT_MAGIC0: begin
            magic0_seen = (w.data_byte == MAGIC0_BYTE);
            phase_now = AT_MAGIC1;
         end
         AT_MAGIC1: begin
            // both magic bytes are judged together on the second one
            if (!(magic0_seen && w.data_byte == MAGIC1_BYTE)) begin
               phase_now = AT_IDLE;
               row.status = STATUS_BAD_MAGIC;
               expected_rows.push_back(row);
            end else begin
               phase_now = AT_MODE;
            end
         end
         AT_MODE: begin
            // only bit zero of the mode byte matters
            wide = w.data_byte[0];
            phase_now = AT_HEIGHT;
         end
         AT_HEIGHT: begin
            rows_per_glyph = w.data_byte;
            glyph_no = '0;
            row_no = '0;
            if (w.data_byte == 8'd0) begin
               phase_now = AT_IDLE;
               row.status = STATUS_ZERO_HEIGHT;
               expected_rows.push_back(row);
            end else begin
               phase_now = AT_ROWS;
            end
         end
         AT_ROWS: begin
            glyph_total = wide ? 2 * GLYPHS_PER_MODE_STEP : GLYPHS_PER_MODE_STEP;
            last_row = (int'(row_no) + 1 == int'(rows_per_glyph));
            last_glyph = (int'(glyph_no) + 1 == int'(glyph_total));
            row.status = STATUS_ROW;
            row.glyph_index = glyph_no;
            row.row_index = row_no;
            row.glyph_height = rows_per_glyph;
            row.pixels = fan_out_row(w.data_byte);
            row.last = last_row && last_glyph;
            expected_rows.push_back(row);
            if (last_row) begin
               row_no = '0;
               glyph_no = glyph_no + 9'd1;
               // after the final row everything up to a start is ignored
               if (last_glyph) phase_now = AT_IDLE;
            end else begin
               row_no = row_no + 8'd1;
            end
         end
         default: begin
            phase_now = AT_IDLE;
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch in %s: got %0h, want %0h", what, got, want);
      error_count++;
   endtask

   // sampled on the rising edge: predict from accepted bytes, then check results
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) decode_byte(req_word);
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               report_mismatch("unexpected word", rsp_word.pixels, '0);
            end else begin
               want = expected_rows.pop_front();
               if (rsp_word.status !== want.status)
                  report_mismatch("status", 64'(rsp_word.status), 64'(want.status));
               if (rsp_word.glyph_index !== want.glyph_index)
                  report_mismatch("glyph_index", 64'(rsp_word.glyph_index),
                                  64'(want.glyph_index));
               if (rsp_word.row_index !== want.row_index)
                  report_mismatch("row_index", 64'(rsp_word.row_index),
                                  64'(want.row_index));
               if (rsp_word.glyph_height !== want.glyph_height)
                  report_mismatch("glyph_height", 64'(rsp_word.glyph_height),
                                  64'(want.glyph_height));
               if (rsp_word.pixels !== want.pixels)
                  report_mismatch("pixels", rsp_word.pixels, want.pixels);
               if (rsp_word.last !== want.last)
                  report_mismatch("last", 64'(rsp_word.last), 64'(want.last));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // watchdog: too long without any word moving on either channel
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: random ready bursts, plus one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            long_hold_req = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance;
   // valid stays high between back-to-back words
   task automatic send_word(input logic [7:0] b, input logic sof);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{data_byte: b, start_of_font: sof};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // sender goes quiet until every predicted word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_header(input logic [7:0] mode, input logic [7:0] h,
                              input logic sof);
      send_word(MAGIC0_BYTE, sof);
      send_word(MAGIC1_BYTE, 1'b0);
      send_word(mode, 1'b0);
      send_word(h, 1'b0);
   endtask

   task automatic send_rows(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) send_word(8'($urandom), 1'b0);
   endtask

   // first bytes after reset parse as a header with no start flag
   task automatic test_header_without_start();
      send_header(8'h00, 8'd2, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hA5, 1'b0);
      wait_for_drain();
   endtask

   // bad magic in either byte, zero height, bytes dropped while idle
   task automatic test_header_errors();
      send_word(8'h37, 1'b1);
      send_word(MAGIC1_BYTE, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(MAGIC0_BYTE, 1'b1);
      send_word(8'h05, 1'b0);
      send_header(8'h00, 8'd0, 1'b1);
      send_word(8'h5A, 1'b0);
      wait_for_drain();
   endtask

   // upper mode bits set with the wide bit, then upper bits alone
   task automatic test_mode_bits();
      send_header(8'hFF, 8'd255, 1'b1);
      send_word(8'h80, 1'b0);
      send_word(8'h01, 1'b0);
      send_header(8'hFE, 8'd1, 1'b1);
      send_word(8'h7E, 1'b0);
      wait_for_drain();
   endtask

   // complete narrow and wide fonts reach the marked final row,
   // a tall font reaches the deepest row index
   task automatic test_full_fonts();
      send_header(8'h00, 8'd1, 1'b1);
      send_rows(GLYPHS_PER_MODE_STEP);
      send_rows(3);
      send_header(8'h01, 8'd1, 1'b1);
      send_rows(2 * GLYPHS_PER_MODE_STEP);
      send_rows(2);
      send_header(8'h00, 8'd255, 1'b1);
      send_rows(300);
      wait_for_drain();
   endtask

   // receiver holds off long enough that the block stalls its input
   task automatic test_backpressure();
      send_header(8'h00, 8'd1, 1'b1);
      long_hold_req = 1'b1;
      send_rows(GLYPHS_PER_MODE_STEP);
      wait_for_drain();
   endtask

   // one random font sequence: mostly well formed, some broken or noise
   task automatic send_random_sequence();
      int unsigned kind;
      int unsigned h;
      logic [7:0]  b0;
      logic [7:0]  b1;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 255) : $urandom_range(1, 4);
         if ($urandom_range(0, 7) == 0) begin
            // whole narrow font followed by up to three trailing bytes
            send_header(8'($urandom) & 8'hFE, 8'd1, 1'b1);
            send_rows(GLYPHS_PER_MODE_STEP);
            send_rows($urandom_range(0, 3));
         end else begin
            // truncated font, the next start cuts it off
            send_header(8'($urandom), 8'(h), 1'b1);
            send_rows($urandom_range(0, 3 * h + 5 > 40 ? 40 : 3 * h + 5));
         end
      end else if (kind == 6) begin
         b0 = $urandom_range(0, 1) ? MAGIC0_BYTE : 8'($urandom);
         b1 = $urandom_range(0, 1) ? MAGIC1_BYTE : 8'($urandom);
         send_word(b0, 1'b1);
         send_word(b1, 1'b0);
      end else if (kind == 7) begin
         send_header(8'($urandom), 8'd0, 1'b1);
      end else if (kind == 8) begin
         // noise, a start may land anywhere
         repeat ($urandom_range(1, 8))
            send_word(8'($urandom), ($urandom_range(0, 3) == 0));
      end else begin
         // header cut short by the next start
         send_word(MAGIC0_BYTE, 1'b1);
         if ($urandom_range(0, 1)) send_word(MAGIC1_BYTE, 1'b0);
         if ($urandom_range(0, 1)) send_word(8'($urandom), 1'b0);
      end
   endtask

   task automatic test_random_streams();
      int unsigned first;
      first = parsed_bytes;
      while (parsed_bytes - first < RANDOM_ITEMS) begin
         if (parsed_bytes - first > RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
         send_random_sequence();
         // now and then let everything drain between sequences
         if ($urandom_range(0, 15) == 0) wait_for_drain();
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_header_without_start();
      test_header_errors();
      test_mode_bits();
      test_full_fonts();
      test_backpressure();
      test_random_streams();
      if (expected_rows.size() != 0)
         report_mismatch("words never seen", 64'(expected_rows.size()), '0);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
